@@ sv/ffba_pkg.sv @@
`default_nettype none
package ffba_pkg;

  // field widths
  localparam int ACT_W       = 2;
  localparam int ADDR_W      = 48;
  localparam int BYTES_W     = 41;
  localparam int STAT_W      = 3;
  localparam int START_W     = 19;
  localparam int UNITS_W     = 20;
  localparam int REQ_UNITS_W = 21;
  localparam int UNIT_SHIFT  = 21;
  localparam int CFG_DW      = 64;
  localparam int CFG_AW      = 4;

  localparam logic [UNITS_W-1:0] POOL_UNITS_MAX = 20'd524288;
  localparam logic [UNITS_W-1:0] POOL_UNITS_RST = 20'd64;

  // action codes
  localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RESIZE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FREE   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOMEM   = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd2;
  localparam logic [STAT_W-1:0] ST_INVALID = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

  // configuration register indexes
  localparam logic REG_POOL_BASE  = 1'b0;
  localparam logic REG_POOL_UNITS = 1'b1;

  // one table entry
  typedef struct packed {
    logic [START_W-1:0] start;
    logic [UNITS_W-1:0] units;
  } entry_t;

  // datapath commands
  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_DECODE, CMD_READ_IDX, CMD_SCAN, CMD_TAIL,
    CMD_READ_PREV, CMD_WRITE_DEC, CMD_INSERT, CMD_FIND, CMD_NOTFOUND,
    CMD_RESIZE, CMD_FREE_UPD, CMD_READ_NEXT, CMD_WRITE_INC, CMD_FREE_END,
    CMD_FINISH
  } cmd_t;

  // datapath status toward the controller
  typedef struct packed {
    logic pre_fail;
    logic is_alloc;
    logic is_resize;
    logic empty;
    logic gap_ok;
    logic scan_last;
    logic tail_ok;
    logic at_pos;
    logic find_end;
    logic match;
    logic shdn_end;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ sv/ffba_req_if.sv @@
`default_nettype none
interface ffba_req_if;
  logic                            valid;
  logic                            ready;
  logic [ffba_pkg::ACT_W-1:0]      action;
  logic [ffba_pkg::ADDR_W-1:0]     request_address;
  logic [ffba_pkg::BYTES_W-1:0]    request_bytes;

  modport source (output valid, action, request_address, request_bytes, input ready);
  modport sink   (input valid, action, request_address, request_bytes, output ready);
endinterface
`default_nettype wire

@@ sv/ffba_rsp_if.sv @@
`default_nettype none
interface ffba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ffba_pkg::STAT_W-1:0]  status;
  logic [ffba_pkg::ADDR_W-1:0]  block_address;

  modport source (output valid, status, block_address, input ready);
  modport sink   (input valid, status, block_address, output ready);
endinterface
`default_nettype wire

@@ sv/ffba_ctrl.sv @@
`default_nettype none
module ffba_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ffba_pkg::dp_stat_t stat,
  output ffba_pkg::cmd_t          cmd
);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_DECODE   = 18'h00002,
    S_SCAN_RD  = 18'h00004,
    S_SCAN_CHK = 18'h00008,
    S_TAIL     = 18'h00010,
    S_SHUP_CHK = 18'h00020,
    S_SHUP_RD  = 18'h00040,
    S_SHUP_WR  = 18'h00080,
    S_INSERT   = 18'h00100,
    S_FIND_RD  = 18'h00200,
    S_FIND_CHK = 18'h00400,
    S_RESIZE   = 18'h00800,
    S_FREE_UPD = 18'h01000,
    S_SHDN_CHK = 18'h02000,
    S_SHDN_RD  = 18'h04000,
    S_SHDN_WR  = 18'h08000,
    S_FREE_END = 18'h10000,
    S_FINISH   = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd       = ffba_pkg::CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = ffba_pkg::CMD_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd = ffba_pkg::CMD_DECODE;
        if (stat.pre_fail)      state_nxt = S_FINISH;
        else if (!stat.is_alloc) state_nxt = S_FIND_RD;
        else if (stat.empty)    state_nxt = S_INSERT;
        else                    state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd       = ffba_pkg::CMD_READ_IDX;
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd = ffba_pkg::CMD_SCAN;
        if (stat.gap_ok)         state_nxt = S_SHUP_CHK;
        else if (stat.scan_last) state_nxt = S_TAIL;
        else                     state_nxt = S_SCAN_RD;
      end
      S_TAIL: begin
        cmd       = ffba_pkg::CMD_TAIL;
        state_nxt = stat.tail_ok ? S_SHUP_CHK : S_FINISH;
      end
      S_SHUP_CHK: begin
        state_nxt = stat.at_pos ? S_INSERT : S_SHUP_RD;
      end
      S_SHUP_RD: begin
        cmd       = ffba_pkg::CMD_READ_PREV;
        state_nxt = S_SHUP_WR;
      end
      S_SHUP_WR: begin
        cmd       = ffba_pkg::CMD_WRITE_DEC;
        state_nxt = S_SHUP_CHK;
      end
      S_INSERT: begin
        cmd       = ffba_pkg::CMD_INSERT;
        state_nxt = S_FINISH;
      end
      S_FIND_RD: begin
        if (stat.find_end) begin
          cmd       = ffba_pkg::CMD_NOTFOUND;
          state_nxt = S_FINISH;
        end else begin
          cmd       = ffba_pkg::CMD_READ_IDX;
          state_nxt = S_FIND_CHK;
        end
      end
      S_FIND_CHK: begin
        cmd = ffba_pkg::CMD_FIND;
        if (!stat.match)         state_nxt = S_FIND_RD;
        else if (stat.is_resize) state_nxt = S_RESIZE;
        else                     state_nxt = S_FREE_UPD;
      end
      S_RESIZE: begin
        cmd       = ffba_pkg::CMD_RESIZE;
        state_nxt = S_FINISH;
      end
      S_FREE_UPD: begin
        cmd       = ffba_pkg::CMD_FREE_UPD;
        state_nxt = S_SHDN_CHK;
      end
      S_SHDN_CHK: begin
        state_nxt = stat.shdn_end ? S_FREE_END : S_SHDN_RD;
      end
      S_SHDN_RD: begin
        cmd       = ffba_pkg::CMD_READ_NEXT;
        state_nxt = S_SHDN_WR;
      end
      S_SHDN_WR: begin
        cmd       = ffba_pkg::CMD_WRITE_INC;
        state_nxt = S_SHDN_CHK;
      end
      S_FREE_END: begin
        cmd       = ffba_pkg::CMD_FREE_END;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd       = ffba_pkg::CMD_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

@@ sv/ffba_dp.sv @@
`default_nettype none
module ffba_dp #(
  parameter int MAX_BLOCKS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ffba_pkg::cmd_t                cmd,
  output ffba_pkg::dp_stat_t                 stat,
  // request payload
  input  wire logic [ffba_pkg::ACT_W-1:0]    in_action,
  input  wire logic [ffba_pkg::ADDR_W-1:0]   in_address,
  input  wire logic [ffba_pkg::BYTES_W-1:0]  in_bytes,
  // result register
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ffba_pkg::STAT_W-1:0]        out_status,
  output logic [ffba_pkg::ADDR_W-1:0]        out_address,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_sel,
  input  wire logic [ffba_pkg::CFG_DW-1:0]   cfg_wdata,
  output logic [ffba_pkg::CFG_DW-1:0]        cfg_rdata
);

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int UW = ffba_pkg::UNITS_W;
  localparam int RW = ffba_pkg::REQ_UNITS_W;
  localparam int SW = ffba_pkg::START_W;
  localparam int AD = ffba_pkg::ADDR_W;

  // block table
  ffba_pkg::entry_t mem [MAX_BLOCKS];
  ffba_pkg::entry_t rdata_r;
  ffba_pkg::entry_t wr_data;
  logic             mem_we, mem_re;
  logic [CW-1:0]    wr_idx, rd_idx;

  // request and work registers
  logic [ffba_pkg::ACT_W-1:0]  act_r;
  logic [AD-1:0]               addr_r;
  logic                        bytes_zero_r;
  logic [RW-1:0]               units_r;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic [CW-1:0]               pos_r, count_r;
  logic [SW-1:0]               start_r;
  logic [UW-1:0]               prev_end_r, old_r;
  logic [UW-1:0]               free_r, used_r, pool_r;
  logic [AD-1:0]               base_r;
  logic [ffba_pkg::STAT_W-1:0] status_r, pre_status;
  logic [ffba_pkg::BYTES_W-1:0] bytes_m1;

  // derived values
  logic [UW-1:0] rd_end, gap, tail, pool_new, free_new;
  logic [RW-1:0] fit_room;
  logic [AD-1:0] rd_addr_cmp, res_addr;
  logic          fit_ok;

  assign bytes_m1    = in_bytes - 1'b1;
  assign rd_end      = UW'(rdata_r.start) + rdata_r.units;
  assign gap         = (UW'(rdata_r.start) > prev_end_r) ? UW'(rdata_r.start) - prev_end_r
                                                         : '0;
  assign tail        = (pool_r > prev_end_r) ? pool_r - prev_end_r : '0;
  assign fit_room    = RW'(free_r) + RW'(old_r);
  assign fit_ok      = (units_r <= fit_room);
  assign rd_addr_cmp = base_r + (AD'(rdata_r.start) << ffba_pkg::UNIT_SHIFT);
  assign res_addr    = base_r + (AD'(start_r) << ffba_pkg::UNIT_SHIFT);

  // early checks on the latched request
  always_comb begin
    case (act_r)
      ffba_pkg::ACT_ALLOC: begin
        if (bytes_zero_r)                pre_status = ffba_pkg::ST_INVALID;
        else if (units_r > RW'(free_r))  pre_status = ffba_pkg::ST_NOMEM;
        else if (count_r >= CW'(MAX_BLOCKS)) pre_status = ffba_pkg::ST_FULL;
        else                             pre_status = ffba_pkg::ST_OK;
      end
      ffba_pkg::ACT_RESIZE:
        pre_status = (bytes_zero_r || addr_r == '0) ? ffba_pkg::ST_INVALID : ffba_pkg::ST_OK;
      ffba_pkg::ACT_FREE:
        pre_status = (addr_r == '0) ? ffba_pkg::ST_INVALID : ffba_pkg::ST_OK;
      default: pre_status = ffba_pkg::ST_INVALID;
    endcase
  end

  // status toward the controller
  always_comb begin
    stat.pre_fail  = (pre_status != ffba_pkg::ST_OK);
    stat.is_alloc  = (act_r == ffba_pkg::ACT_ALLOC);
    stat.is_resize = (act_r == ffba_pkg::ACT_RESIZE);
    stat.empty     = (count_r == '0);
    stat.gap_ok    = (idx_r != '0) && (RW'(gap) >= units_r);
    stat.scan_last = (CW'(idx_r + 1'b1) == count_r);
    stat.tail_ok   = (RW'(tail) >= units_r);
    stat.at_pos    = (idx_r == pos_r);
    stat.find_end  = (idx_r == count_r);
    stat.match     = (rd_addr_cmp == addr_r);
    stat.shdn_end  = (CW'(idx_r + 1'b1) >= count_r);
    stat.out_free  = !out_valid || out_ready;
  end

  // table port control
  always_comb begin
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    wr_idx  = idx_r;
    rd_idx  = idx_r;
    wr_data = rdata_r;
    case (cmd) inside
      ffba_pkg::CMD_READ_IDX:  mem_re = 1'b1;
      ffba_pkg::CMD_READ_PREV: begin
        mem_re = 1'b1;
        rd_idx = idx_r - 1'b1;
      end
      ffba_pkg::CMD_READ_NEXT: begin
        mem_re = 1'b1;
        rd_idx = idx_r + 1'b1;
      end
      ffba_pkg::CMD_WRITE_DEC,
      ffba_pkg::CMD_WRITE_INC: mem_we = 1'b1;
      ffba_pkg::CMD_INSERT: begin
        mem_we  = 1'b1;
        wr_idx  = pos_r;
        wr_data = '{start: start_r, units: units_r[UW-1:0]};
      end
      ffba_pkg::CMD_RESIZE: begin
        mem_we  = fit_ok;
        wr_idx  = pos_r;
        wr_data = '{start: rdata_r.start, units: units_r[UW-1:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_idx[AW-1:0]] <= wr_data;
    if (mem_re) rdata_r <= mem[rd_idx[AW-1:0]];
  end

  // configuration write values
  assign pool_new  = (cfg_wdata[UW-1:0] > ffba_pkg::POOL_UNITS_MAX) ? ffba_pkg::POOL_UNITS_MAX
                                                                   : cfg_wdata[UW-1:0];
  assign free_new  = (pool_new > used_r) ? pool_new - used_r : '0;
  assign cfg_rdata = (cfg_sel == ffba_pkg::REG_POOL_UNITS) ? ffba_pkg::CFG_DW'(pool_r)
                                                          : ffba_pkg::CFG_DW'(base_r);

  // scan index
  always_comb begin
    idx_nxt = idx_r;
    case (cmd)
      ffba_pkg::CMD_DECODE:    idx_nxt = '0;
      ffba_pkg::CMD_SCAN:      idx_nxt = stat.gap_ok ? count_r : CW'(idx_r + 1'b1);
      ffba_pkg::CMD_TAIL:      idx_nxt = count_r;
      ffba_pkg::CMD_WRITE_DEC: idx_nxt = idx_r - 1'b1;
      ffba_pkg::CMD_WRITE_INC: idx_nxt = idx_r + 1'b1;
      ffba_pkg::CMD_FIND:      idx_nxt = stat.match ? idx_r : CW'(idx_r + 1'b1);
      ffba_pkg::CMD_FREE_UPD:  idx_nxt = pos_r;
      default: ;
    endcase
  end

  // request, work and index registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    case (cmd)
      ffba_pkg::CMD_LOAD: begin
        act_r        <= in_action;
        addr_r       <= in_address;
        bytes_zero_r <= (in_bytes == '0);
        units_r      <= RW'(bytes_m1 >> ffba_pkg::UNIT_SHIFT) + 1'b1;
      end
      ffba_pkg::CMD_DECODE: begin
        pos_r   <= '0;
        start_r <= '0;
      end
      ffba_pkg::CMD_SCAN: begin
        if (stat.gap_ok) begin
          pos_r   <= idx_r;
          start_r <= prev_end_r[SW-1:0];
        end
        prev_end_r <= rd_end;
      end
      ffba_pkg::CMD_TAIL: begin
        pos_r   <= count_r;
        start_r <= prev_end_r[SW-1:0];
      end
      ffba_pkg::CMD_FIND: begin
        if (stat.match) begin
          pos_r <= idx_r;
          old_r <= rdata_r.units;
        end
      end
      default: ;
    endcase
  end

  // control state: counts, status, configuration, result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      free_r    <= ffba_pkg::POOL_UNITS_RST;
      used_r    <= '0;
      pool_r    <= ffba_pkg::POOL_UNITS_RST;
      base_r    <= '0;
      status_r  <= ffba_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_sel == ffba_pkg::REG_POOL_UNITS) begin
          pool_r <= pool_new;
          free_r <= free_new;
        end else begin
          base_r <= cfg_wdata[AD-1:0];
        end
      end
      // result valid: load on finish, drop on accept
      if (cmd == ffba_pkg::CMD_FINISH)  out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (cmd)
        ffba_pkg::CMD_DECODE: status_r <= pre_status;
        ffba_pkg::CMD_TAIL: begin
          if (!stat.tail_ok) status_r <= ffba_pkg::ST_NOMEM;
        end
        ffba_pkg::CMD_NOTFOUND: status_r <= ffba_pkg::ST_UNKNOWN;
        ffba_pkg::CMD_INSERT: begin
          count_r <= count_r + 1'b1;
          free_r  <= free_r - units_r[UW-1:0];
          used_r  <= used_r + units_r[UW-1:0];
        end
        ffba_pkg::CMD_RESIZE: begin
          if (fit_ok) begin
            free_r <= free_r + old_r - units_r[UW-1:0];
            used_r <= used_r - old_r + units_r[UW-1:0];
          end else begin
            status_r <= ffba_pkg::ST_NOMEM;
          end
        end
        ffba_pkg::CMD_FREE_UPD: begin
          free_r <= free_r + old_r;
          used_r <= used_r - old_r;
        end
        ffba_pkg::CMD_FREE_END: count_r <= count_r - 1'b1;
        ffba_pkg::CMD_FINISH: begin
          out_status  <= status_r;
          out_address <= (status_r == ffba_pkg::ST_OK && act_r == ffba_pkg::ACT_ALLOC)
                         ? res_addr : '0;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/first_fit_block_allocator_top.sv @@
// Channel   Direction  Handshake      Payload
// in_req    in         valid/ready    action, request_address, request_bytes
// out_rsp   out        valid/ready    status, block_address
// cfg (APB) in         psel/penable   pool_base @0x0, pool_units @0x8 (64-bit data)
//
// One request at a time. Allocate scans the table for the first gap, then moves entries up
// (or takes the tail, or inserts at once on an empty table); resize and an unknown address
// search the table; free searches it and moves entries down; an early reject goes straight
// to the result. The block table is read one entry per step.
// rst_n is synchronous: it empties the table and loads the register defaults.
// A new request is taken while a result waits on out_rsp; the next result holds in FINISH.
`default_nettype none
module first_fit_block_allocator_top #(
  parameter int MAX_BLOCKS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ffba_req_if.sink                           in_req,
  ffba_rsp_if.source                         out_rsp,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ffba_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [ffba_pkg::CFG_DW-1:0]   pwdata,
  output logic      [ffba_pkg::CFG_DW-1:0]   prdata,
  output logic                               pready
);

  ffba_pkg::cmd_t     cmd;
  ffba_pkg::dp_stat_t stat;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_action   (in_req.action),
    .in_address  (in_req.request_address),
    .in_bytes    (in_req.request_bytes),
    .out_valid   (out_rsp.valid),
    .out_ready   (out_rsp.ready),
    .out_status  (out_rsp.status),
    .out_address (out_rsp.block_address),
    .cfg_we      (cfg_we),
    .cfg_sel     (paddr[3]),
    .cfg_wdata   (pwdata),
    .cfg_rdata   (prdata)
  );

`ifndef SYNTHESIS
  // an accepted request is decoded in the next cycle
  a_load_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> cmd == ffba_pkg::CMD_DECODE)
    else $error("request not decoded after accept");

  // insertion only once the table has been opened at the slot
  a_insert_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == ffba_pkg::CMD_INSERT |-> stat.at_pos)
    else $error("insert away from opened slot");

  // a result is loaded only into a free output register
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == ffba_pkg::CMD_FINISH |-> stat.out_free)
    else $error("result overwrites pending result");

  // a new result appears only after a finish command
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_rsp.valid) |-> $past(cmd == ffba_pkg::CMD_FINISH))
    else $error("result without finish");
`endif

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
module tb_top;

  localparam int TABLE_DEPTH = 64;
  localparam int STALL_LIMIT = 20000;
  localparam logic [ffba_pkg::CFG_AW-1:0] ADDR_POOL_BASE  = 4'h0;
  localparam logic [ffba_pkg::CFG_AW-1:0] ADDR_POOL_UNITS = 4'h8;
  localparam logic [ffba_pkg::ACT_W-1:0]  ACT_UNUSED      = 2'd3;

  // expected result of one request
  typedef struct {
    logic [ffba_pkg::STAT_W-1:0] status;
    logic [ffba_pkg::ADDR_W-1:0] block_address;
  } alloc_result_t;

  // shadow of the allocator: block table, counters and registers
  class pool_scoreboard;
    logic [ffba_pkg::ADDR_W-1:0]  base;
    logic [ffba_pkg::UNITS_W-1:0] units_cfg;
    logic [ffba_pkg::START_W-1:0] blk_start[TABLE_DEPTH];
    logic [ffba_pkg::UNITS_W-1:0] blk_units[TABLE_DEPTH];
    int unsigned                  blk_cnt;
    logic [ffba_pkg::UNITS_W-1:0] free_u;
    logic [ffba_pkg::UNITS_W-1:0] used_u;
    alloc_result_t                pending[$];
    int unsigned                  errors;

    function void clear();
      base = '0;
      units_cfg = ffba_pkg::POOL_UNITS_RST;
      blk_cnt = 0;
      free_u = ffba_pkg::POOL_UNITS_RST;
      used_u = '0;
    endfunction

    function void set_reg(logic [ffba_pkg::CFG_AW-1:0] a, logic [ffba_pkg::CFG_DW-1:0] v);
      logic [ffba_pkg::UNITS_W-1:0] u;
      if (a == ADDR_POOL_BASE) begin
        base = v[ffba_pkg::ADDR_W-1:0];
      end else begin
        u = v[ffba_pkg::UNITS_W-1:0];
        units_cfg = (u > ffba_pkg::POOL_UNITS_MAX) ? ffba_pkg::POOL_UNITS_MAX : u;
        free_u = (units_cfg > used_u) ? units_cfg - used_u : '0;
      end
    endfunction

    function logic [ffba_pkg::ADDR_W-1:0] addr_of(logic [ffba_pkg::START_W-1:0] s);
      logic [63:0] t;
      t = 64'(base) + (64'(s) << ffba_pkg::UNIT_SHIFT);
      return t[ffba_pkg::ADDR_W-1:0];
    endfunction

    function int lookup(logic [ffba_pkg::ADDR_W-1:0] a);
      for (int i = 0; i < blk_cnt; i++)
        if (addr_of(blk_start[i]) == a) return i;
      return -1;
    endfunction

    function alloc_result_t allocate(logic [ffba_pkg::BYTES_W-1:0] nbytes);
      alloc_result_t r;
      logic [63:0] u;
      int pos;
      logic [31:0] s, e, g;
      r.status = ffba_pkg::ST_OK;
      r.block_address = '0;
      u = ((64'(nbytes) - 1) >> ffba_pkg::UNIT_SHIFT) + 1;
      if (nbytes == 0) begin r.status = ffba_pkg::ST_INVALID; return r; end
      if (u > 64'(free_u)) begin r.status = ffba_pkg::ST_NOMEM; return r; end
      if (blk_cnt >= TABLE_DEPTH) begin r.status = ffba_pkg::ST_FULL; return r; end
      pos = 0;
      s = 0;
      if (blk_cnt != 0) begin
        pos = -1;
        for (int i = 0; i + 1 < blk_cnt; i++) begin
          e = 32'(blk_start[i]) + 32'(blk_units[i]);
          g = (32'(blk_start[i+1]) > e) ? 32'(blk_start[i+1]) - e : 0;
          if (64'(g) >= u) begin pos = i + 1; s = e; break; end
        end
        if (pos < 0) begin
          e = 32'(blk_start[blk_cnt-1]) + 32'(blk_units[blk_cnt-1]);
          g = (32'(units_cfg) > e) ? 32'(units_cfg) - e : 0;
          if (64'(g) < u) begin r.status = ffba_pkg::ST_NOMEM; return r; end
          pos = blk_cnt;
          s = e;
        end
      end
      for (int i = blk_cnt; i > pos; i--) begin
        blk_start[i] = blk_start[i-1];
        blk_units[i] = blk_units[i-1];
      end
      blk_start[pos] = s[ffba_pkg::START_W-1:0];
      blk_units[pos] = u[ffba_pkg::UNITS_W-1:0];
      blk_cnt++;
      free_u -= u[ffba_pkg::UNITS_W-1:0];
      used_u += u[ffba_pkg::UNITS_W-1:0];
      r.block_address = addr_of(s[ffba_pkg::START_W-1:0]);
      return r;
    endfunction

    function logic [ffba_pkg::STAT_W-1:0] resize(logic [ffba_pkg::ADDR_W-1:0] a,
                                                logic [ffba_pkg::BYTES_W-1:0] nbytes);
      int k;
      logic [63:0] u;
      if (nbytes == 0 || a == 0) return ffba_pkg::ST_INVALID;
      k = lookup(a);
      if (k < 0) return ffba_pkg::ST_UNKNOWN;
      u = ((64'(nbytes) - 1) >> ffba_pkg::UNIT_SHIFT) + 1;
      if (u > 64'(free_u) + 64'(blk_units[k])) return ffba_pkg::ST_NOMEM;
      free_u = free_u + blk_units[k] - u[ffba_pkg::UNITS_W-1:0];
      used_u = used_u - blk_units[k] + u[ffba_pkg::UNITS_W-1:0];
      blk_units[k] = u[ffba_pkg::UNITS_W-1:0];
      return ffba_pkg::ST_OK;
    endfunction

    function logic [ffba_pkg::STAT_W-1:0] release_block(logic [ffba_pkg::ADDR_W-1:0] a);
      int k;
      if (a == 0) return ffba_pkg::ST_INVALID;
      k = lookup(a);
      if (k < 0) return ffba_pkg::ST_UNKNOWN;
      free_u += blk_units[k];
      used_u -= blk_units[k];
      for (int i = k; i + 1 < blk_cnt; i++) begin
        blk_start[i] = blk_start[i+1];
        blk_units[i] = blk_units[i+1];
      end
      blk_cnt--;
      return ffba_pkg::ST_OK;
    endfunction

    // note an accepted request and queue its expected result
    function void note_request(logic [ffba_pkg::ACT_W-1:0] act,
                               logic [ffba_pkg::ADDR_W-1:0] a,
                               logic [ffba_pkg::BYTES_W-1:0] nbytes);
      alloc_result_t r;
      r.block_address = '0;
      case (act)
        ffba_pkg::ACT_ALLOC:  r = allocate(nbytes);
        ffba_pkg::ACT_RESIZE: r.status = resize(a, nbytes);
        ffba_pkg::ACT_FREE:   r.status = release_block(a);
        default:              r.status = ffba_pkg::ST_INVALID;
      endcase
      pending = {pending, r};
    endfunction

    function void check_result(logic [ffba_pkg::STAT_W-1:0] st,
                               logic [ffba_pkg::ADDR_W-1:0] a);
      alloc_result_t r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d addr=%h", $time, st, a);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (st !== r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, r.status, st);
        errors++;
      end
      if (a !== r.block_address) begin
        $display("%0t: block_address expected %h actual %h", $time, r.block_address, a);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [ffba_pkg::CFG_AW-1:0] paddr;
  logic [ffba_pkg::CFG_DW-1:0] pwdata, prdata;
  int src_idle_pct, snk_idle_pct;
  int stall_cycles = 0;
  pool_scoreboard sb;
  logic [ffba_pkg::ADDR_W-1:0] live_addrs[$];

  ffba_req_if in_req();
  ffba_rsp_if out_rsp();

  first_fit_block_allocator_top #(
    .MAX_BLOCKS (TABLE_DEPTH)
  ) u_dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_rsp(out_rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random stall, check on acceptance
  always @(posedge clk) begin
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      sb.check_result(out_rsp.status, out_rsp.block_address);
      if (out_rsp.status == ffba_pkg::ST_OK && out_rsp.block_address != 0)
        live_addrs = {live_addrs, out_rsp.block_address};
    end
    out_rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("first_fit_block_allocator_top verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [ffba_pkg::CFG_AW-1:0] a, logic [ffba_pkg::CFG_DW-1:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= v; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(a, v);
    @(posedge clk);
  endtask

  // valid stays up after an accept until the next request or a drain
  task automatic send_request(logic [ffba_pkg::ACT_W-1:0] act,
                              logic [ffba_pkg::ADDR_W-1:0] a,
                              logic [ffba_pkg::BYTES_W-1:0] nbytes);
    while ($urandom_range(99) < src_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.action <= act;
    in_req.request_address <= a;
    in_req.request_bytes <= nbytes;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    sb.note_request(act, a, nbytes);
  endtask

  task automatic drain();
    in_req.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // mostly small sizes, sometimes large or odd
  function automatic logic [ffba_pkg::BYTES_W-1:0] pick_bytes();
    case ($urandom_range(9))
      0: return '0;
      1: return ffba_pkg::BYTES_W'({$urandom, $urandom});
      2: return 41'h100_0000_0000;
      default: return ffba_pkg::BYTES_W'($urandom_range(6 << ffba_pkg::UNIT_SHIFT, 1));
    endcase
  endfunction

  function automatic logic [ffba_pkg::ADDR_W-1:0] pick_addr();
    case ($urandom_range(9))
      0: return '0;
      1: return ffba_pkg::ADDR_W'({$urandom, $urandom});
      default:
        if (live_addrs.size() == 0) return ffba_pkg::ADDR_W'($urandom);
        else return live_addrs[$urandom_range(live_addrs.size() - 1)];
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [ffba_pkg::ACT_W-1:0] act;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19)) inside
        0:       act = ACT_UNUSED;
        [1:8]:   act = ffba_pkg::ACT_ALLOC;
        [9:12]:  act = ffba_pkg::ACT_RESIZE;
        default: act = ffba_pkg::ACT_FREE;
      endcase
      send_request(act, pick_addr(), pick_bytes());
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    sb.errors = 0;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_req.valid = 1'b0; in_req.action = ffba_pkg::ACT_ALLOC;
    in_req.request_address = '0; in_req.request_bytes = '0;
    src_idle_pct = 0; snk_idle_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every action, error paths
    src_idle_pct = 28; snk_idle_pct = 81;
    send_request(ffba_pkg::ACT_ALLOC, '0, '0);
    send_request(ffba_pkg::ACT_ALLOC, '0, 41'd1);
    send_request(ffba_pkg::ACT_ALLOC, '0, 41'h1FF_FFFF_FFFF);
    send_request(ffba_pkg::ACT_ALLOC, '0, 41'd2097152);
    send_request(ffba_pkg::ACT_ALLOC, '0, 41'd2097153);
    send_request(ffba_pkg::ACT_RESIZE, '0, 41'd5);
    send_request(ffba_pkg::ACT_RESIZE, 48'h0000_0020_0000, '0);
    send_request(ffba_pkg::ACT_RESIZE, 48'hFFFF_FFFF_FFFF, 41'd5);
    send_request(ffba_pkg::ACT_RESIZE, 48'h0000_0020_0000, 41'd4194304);
    send_request(ffba_pkg::ACT_ALLOC, '0, 41'd1);
    send_request(ffba_pkg::ACT_RESIZE, 48'h0000_0020_0000, 41'h100_0000_0000);
    send_request(ffba_pkg::ACT_FREE, '0, '0);
    send_request(ffba_pkg::ACT_FREE, 48'h0000_0020_0000, 41'h1FF_FFFF_FFFF);
    send_request(ffba_pkg::ACT_ALLOC, 48'hFFFF_FFFF_FFFF, 41'd1);
    send_request(ACT_UNUSED, 48'hFFFF_FFFF_FFFF, 41'h1FF_FFFF_FFFF);
    send_request(ffba_pkg::ACT_FREE, 48'h0000_0000_0000 + (48'd1 << 21), '0);
    // fill table until full: one-unit blocks, the last requests see table-full
    drain();
    write_reg(ADDR_POOL_UNITS, 64'd200);
    src_idle_pct = 0; snk_idle_pct = 0;
    for (int i = 0; i < 66; i++) send_request(ffba_pkg::ACT_ALLOC, '0, 41'd1000);
    drain();

    // reset pool to fresh by freeing everything
    for (int i = 0; i < 70; i++)
      send_request(ffba_pkg::ACT_FREE, sb.addr_of(sb.blk_start[0]), '0);
    drain();
    live_addrs.delete();

    // random phase 1: sender 28, receiver 81, offset base
    write_reg(ADDR_POOL_BASE, 64'h0000_1234_5660_0000);
    write_reg(ADDR_POOL_UNITS, 64'd64);
    src_idle_pct = 28; snk_idle_pct = 81;
    random_phase(120);
    // hold the sender until every result is back
    drain();

    // random phase 2: swapped idling, top-of-range base wraps addresses
    write_reg(ADDR_POOL_BASE, 64'hFFFF_FFE0_0000);
    write_reg(ADDR_POOL_UNITS, 64'hFFFFF);
    src_idle_pct = 81; snk_idle_pct = 28;
    random_phase(120);
    drain();

    // random phase 3: no idling, empty pool, then the largest pool
    write_reg(ADDR_POOL_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(ADDR_POOL_UNITS, 64'd0);
    src_idle_pct = 0; snk_idle_pct = 0;
    random_phase(30);
    drain();
    write_reg(ADDR_POOL_BASE, 64'd0);
    write_reg(ADDR_POOL_UNITS, 64'd524288);
    random_phase(80);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("first_fit_block_allocator_top verification clean");
    end else begin
      $display("first_fit_block_allocator_top verification failed");
    end
    $finish;
  end
endmodule
